@@ hw/rtl/plbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbl_pkg
// Shared codes, constants and state types of the piecewise-linear bound
// lookup block.
// ----------------------------------------------------------------------------
package plbl_pkg;

  // Command codes of an input beat. The last code is unused; it changes nothing but still returns an OK result beat.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Status codes of a result beat.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_LOW   = 3'd1;
  localparam logic [2:0] ST_HIGH  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_ORDER = 3'd5;

  // Interpolation weight is Q0.16.
  localparam int WEIGHT_BITS = 16;
  localparam int WEIGHT_HALF = 32768;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_SEARCH,
    TOP_INTERP
  } top_state_t;

  // Interpolator states.
  typedef enum logic [2:0] {
    IP_IDLE,
    IP_DIV,
    IP_MUL_LO,
    IP_MUL_UP,
    IP_ADD_UP,
    IP_DONE
  } ip_state_t;

endpackage

@@ hw/rtl/plbl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbl_in_if / plbl_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface plbl_in_if #(
  parameter int STATION_BITS = 24,
  parameter int BOUND_BITS   = 16
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [STATION_BITS-1:0]        station;
  logic signed [BOUND_BITS-1:0]   lower_in;
  logic signed [BOUND_BITS-1:0]   upper_in;

  modport source (output valid, cmd, station, lower_in, upper_in, input ready);
  modport sink   (input valid, cmd, station, lower_in, upper_in, output ready);
endinterface

interface plbl_out_if #(
  parameter int BOUND_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [BOUND_BITS-1:0]   lower_out;
  logic signed [BOUND_BITS-1:0]   upper_out;
  logic [2:0]                     status;

  modport source (output valid, lower_out, upper_out, status, input ready);
  modport sink   (input valid, lower_out, upper_out, status, output ready);
endinterface

@@ hw/rtl/piecewise_linear_bound_lookup_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_bound_lookup_top
// Table of stations with lower and upper bounds, kept in a row of cells.
// Queries clamp outside the table and interpolate linearly inside it.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_beat   in   valid/ready    cmd, station, lower_in, upper_in
//  out_beat  out  valid/ready    lower_out, upper_out, status
//
//  Clear, append and unused commands: result in the next cycle.
//  A query walks a token down the cell row; a clamp or an exact station
//  hit ends there, otherwise a 16-step divider and two multiply/add steps
//  follow before the result is registered.
//  One beat is in work at a time; the result register frees the input side.
//  Reset clears the point count; table contents need no clearing.
// ----------------------------------------------------------------------------
module piecewise_linear_bound_lookup_top #(
  parameter int TABLE_DEPTH  = 256,
  parameter int STATION_BITS = 24,
  parameter int BOUND_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  plbl_in_if.sink    in_beat,
  plbl_out_if.source out_beat
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SB = STATION_BITS;
  localparam int BB = BOUND_BITS;

  plbl_pkg::top_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SB-1:0] last_st_r, last_st_nxt;
  logic [SB-1:0] s_r, s_nxt;

  logic          out_vld_r, out_vld_nxt;
  logic [BB-1:0] out_lo_r, out_lo_nxt;
  logic [BB-1:0] out_up_r, out_up_nxt;
  logic [2:0]    out_st_r, out_st_nxt;

  logic in_fire;
  logic wr_en;
  logic launch;
  logic ip_start;
  logic ip_done;
  logic [BB-1:0] ip_lo, ip_up;

  // Token links: one into the first cell, one between each pair of neighboring cells, one out of the last.
  logic          l_vld   [TABLE_DEPTH+1];
  logic [SB-1:0] l_s     [TABLE_DEPTH+1];
  logic          l_hl    [TABLE_DEPTH+1];
  logic [SB-1:0] l_lst   [TABLE_DEPTH+1];
  logic [BB-1:0] l_llo   [TABLE_DEPTH+1];
  logic [BB-1:0] l_lup   [TABLE_DEPTH+1];
  logic          l_hr    [TABLE_DEPTH+1];
  logic [SB-1:0] l_rst   [TABLE_DEPTH+1];
  logic [BB-1:0] l_rlo   [TABLE_DEPTH+1];
  logic [BB-1:0] l_rup   [TABLE_DEPTH+1];

  assign in_beat.ready = (state_r == plbl_pkg::TOP_IDLE) && (!out_vld_r || out_beat.ready);
  assign in_fire       = in_beat.valid && in_beat.ready;

  // Token entry at the head of the row.
  assign l_vld[0] = launch;
  assign l_s[0]   = in_beat.station;
  assign l_hl[0]  = 1'b0;
  assign l_lst[0] = '0;
  assign l_llo[0] = '0;
  assign l_lup[0] = '0;
  assign l_hr[0]  = 1'b0;
  assign l_rst[0] = '0;
  assign l_rlo[0] = '0;
  assign l_rup[0] = '0;

  // Row of point cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    plbl_cell #(
      .CELL_IDX    (i),
      .TABLE_DEPTH (TABLE_DEPTH),
      .STATION_BITS(SB),
      .BOUND_BITS  (BB),
      .CW          (CW)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .count         (count_r),
      .wr_en         (wr_en),
      .wr_st         (in_beat.station),
      .wr_lo         (in_beat.lower_in),
      .wr_up         (in_beat.upper_in),
      .in_vld        (l_vld[i]),
      .in_s          (l_s[i]),
      .in_have_left  (l_hl[i]),
      .in_left_st    (l_lst[i]),
      .in_left_lo    (l_llo[i]),
      .in_left_up    (l_lup[i]),
      .in_have_right (l_hr[i]),
      .in_right_st   (l_rst[i]),
      .in_right_lo   (l_rlo[i]),
      .in_right_up   (l_rup[i]),
      .out_vld       (l_vld[i+1]),
      .out_s         (l_s[i+1]),
      .out_have_left (l_hl[i+1]),
      .out_left_st   (l_lst[i+1]),
      .out_left_lo   (l_llo[i+1]),
      .out_left_up   (l_lup[i+1]),
      .out_have_right(l_hr[i+1]),
      .out_right_st  (l_rst[i+1]),
      .out_right_lo  (l_rlo[i+1]),
      .out_right_up  (l_rup[i+1])
    );
  end

  // Weight divider and bound blending.
  plbl_interp #(
    .STATION_BITS(SB),
    .BOUND_BITS  (BB)
  ) u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ip_start),
    .s       (s_r),
    .left_st (l_lst[TABLE_DEPTH]),
    .left_lo (l_llo[TABLE_DEPTH]),
    .left_up (l_lup[TABLE_DEPTH]),
    .right_st(l_rst[TABLE_DEPTH]),
    .right_lo(l_rlo[TABLE_DEPTH]),
    .right_up(l_rup[TABLE_DEPTH]),
    .done    (ip_done),
    .lo_out  (ip_lo),
    .up_out  (ip_up)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= plbl_pkg::TOP_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    last_st_r <= last_st_nxt;
    s_r       <= s_nxt;
    out_lo_r  <= out_lo_nxt;
    out_up_r  <= out_up_nxt;
    out_st_r  <= out_st_nxt;
  end

  // Command decode, search resolution and result loading.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    last_st_nxt = last_st_r;
    s_nxt       = s_r;
    out_vld_nxt = out_vld_r && !out_beat.ready;
    out_lo_nxt  = out_lo_r;
    out_up_nxt  = out_up_r;
    out_st_nxt  = out_st_r;
    wr_en       = 1'b0;
    launch      = 1'b0;
    ip_start    = 1'b0;
    unique case (state_r)
      plbl_pkg::TOP_IDLE: begin
        if (in_fire) begin
          out_lo_nxt = '0;
          out_up_nxt = '0;
          out_st_nxt = plbl_pkg::ST_OK;
          s_nxt      = in_beat.station;
          case (in_beat.cmd)
            plbl_pkg::CMD_CLEAR: begin
              count_nxt   = '0;
              out_vld_nxt = 1'b1;
            end
            plbl_pkg::CMD_APPEND: begin
              out_vld_nxt = 1'b1;
              if (count_r == CW'(TABLE_DEPTH)) begin
                out_st_nxt = plbl_pkg::ST_FULL;
              end else if ((count_r != '0) && !(in_beat.station > last_st_r)) begin
                out_st_nxt = plbl_pkg::ST_ORDER;
              end else begin
                wr_en       = 1'b1;
                count_nxt   = count_r + 1'b1;
                last_st_nxt = in_beat.station;
              end
            end
            plbl_pkg::CMD_QUERY: begin
              if (count_r == '0) begin
                out_st_nxt  = plbl_pkg::ST_EMPTY;
                out_vld_nxt = 1'b1;
              end else begin
                launch    = 1'b1;
                state_nxt = plbl_pkg::TOP_SEARCH;
              end
            end
            default: begin
              out_vld_nxt = 1'b1;
            end
          endcase
        end
      end
      plbl_pkg::TOP_SEARCH: begin
        if (l_vld[TABLE_DEPTH]) begin
          if (!l_hl[TABLE_DEPTH]) begin
            // At or below the first station.
            out_lo_nxt  = l_rlo[TABLE_DEPTH];
            out_up_nxt  = l_rup[TABLE_DEPTH];
            out_st_nxt  = (s_r < l_rst[TABLE_DEPTH]) ? plbl_pkg::ST_LOW : plbl_pkg::ST_OK;
            out_vld_nxt = 1'b1;
            state_nxt   = plbl_pkg::TOP_IDLE;
          end else if (!l_hr[TABLE_DEPTH]) begin
            // Beyond the last station.
            out_lo_nxt  = l_llo[TABLE_DEPTH];
            out_up_nxt  = l_lup[TABLE_DEPTH];
            out_st_nxt  = plbl_pkg::ST_HIGH;
            out_vld_nxt = 1'b1;
            state_nxt   = plbl_pkg::TOP_IDLE;
          end else if (s_r == l_rst[TABLE_DEPTH]) begin
            // Exactly on a stored station.
            out_lo_nxt  = l_rlo[TABLE_DEPTH];
            out_up_nxt  = l_rup[TABLE_DEPTH];
            out_st_nxt  = plbl_pkg::ST_OK;
            out_vld_nxt = 1'b1;
            state_nxt   = plbl_pkg::TOP_IDLE;
          end else begin
            ip_start  = 1'b1;
            state_nxt = plbl_pkg::TOP_INTERP;
          end
        end
      end
      plbl_pkg::TOP_INTERP: begin
        if (ip_done) begin
          out_lo_nxt  = ip_lo;
          out_up_nxt  = ip_up;
          out_st_nxt  = plbl_pkg::ST_OK;
          out_vld_nxt = 1'b1;
          state_nxt   = plbl_pkg::TOP_IDLE;
        end
      end
      default: begin
        state_nxt = plbl_pkg::TOP_IDLE;
      end
    endcase
  end

  assign out_beat.valid     = out_vld_r;
  assign out_beat.lower_out = out_lo_r;
  assign out_beat.upper_out = out_up_r;
  assign out_beat.status    = out_st_r;

  // Checks.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("point count overflow");
  a_query_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_beat.cmd == plbl_pkg::CMD_QUERY && count_r != '0
    |=> state_r == plbl_pkg::TOP_SEARCH) else $error("query did not start search");
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    l_vld[TABLE_DEPTH] |-> state_r == plbl_pkg::TOP_SEARCH) else $error("stray token");
  a_done_in_interp: assert property (@(posedge clk) disable iff (!rst_n)
    ip_done |-> state_r == plbl_pkg::TOP_INTERP) else $error("stray interp done");

endmodule

@@ hw/rtl/plbl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbl_cell
// One table point. A search token passes through every cycle; the cell
// records itself as the left neighbor when its station lies below the query,
// or as the right neighbor when it is the first at or above it.
// ----------------------------------------------------------------------------
module plbl_cell #(
  parameter int CELL_IDX     = 0,
  parameter int TABLE_DEPTH  = 256,
  parameter int STATION_BITS = 24,
  parameter int BOUND_BITS   = 16,
  parameter int CW           = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Point count and append strobe.
  input  logic [CW-1:0]           count,
  input  logic                    wr_en,
  input  logic [STATION_BITS-1:0] wr_st,
  input  logic [BOUND_BITS-1:0]   wr_lo,
  input  logic [BOUND_BITS-1:0]   wr_up,
  // Token from the previous cell.
  input  logic                    in_vld,
  input  logic [STATION_BITS-1:0] in_s,
  input  logic                    in_have_left,
  input  logic [STATION_BITS-1:0] in_left_st,
  input  logic [BOUND_BITS-1:0]   in_left_lo,
  input  logic [BOUND_BITS-1:0]   in_left_up,
  input  logic                    in_have_right,
  input  logic [STATION_BITS-1:0] in_right_st,
  input  logic [BOUND_BITS-1:0]   in_right_lo,
  input  logic [BOUND_BITS-1:0]   in_right_up,
  // Token to the next cell.
  output logic                    out_vld,
  output logic [STATION_BITS-1:0] out_s,
  output logic                    out_have_left,
  output logic [STATION_BITS-1:0] out_left_st,
  output logic [BOUND_BITS-1:0]   out_left_lo,
  output logic [BOUND_BITS-1:0]   out_left_up,
  output logic                    out_have_right,
  output logic [STATION_BITS-1:0] out_right_st,
  output logic [BOUND_BITS-1:0]   out_right_lo,
  output logic [BOUND_BITS-1:0]   out_right_up
);

  logic [STATION_BITS-1:0] st_r;
  logic [BOUND_BITS-1:0]   lo_r;
  logic [BOUND_BITS-1:0]   up_r;
  logic                    cell_valid;
  logic                    is_left;
  logic                    is_right;

  logic                    vld_r;
  logic [STATION_BITS-1:0] s_r;
  logic                    have_left_r, have_left_nxt;
  logic [STATION_BITS-1:0] left_st_r, left_st_nxt;
  logic [BOUND_BITS-1:0]   left_lo_r, left_lo_nxt;
  logic [BOUND_BITS-1:0]   left_up_r, left_up_nxt;
  logic                    have_right_r, have_right_nxt;
  logic [STATION_BITS-1:0] right_st_r, right_st_nxt;
  logic [BOUND_BITS-1:0]   right_lo_r, right_lo_nxt;
  logic [BOUND_BITS-1:0]   right_up_r, right_up_nxt;

  // The cell holds a point when its index lies below the count.
  assign cell_valid = (CW'(CELL_IDX) < count);

  // Point storage, written by an append that targets this index.
  always_ff @(posedge clk) begin
    if (wr_en && (count == CW'(CELL_IDX))) begin
      st_r <= wr_st;
      lo_r <= wr_lo;
      up_r <= wr_up;
    end
  end

  // Neighbor selection for the passing token.
  always_comb begin
    is_left        = in_vld && cell_valid && (st_r < in_s);
    is_right       = in_vld && cell_valid && !(st_r < in_s) && !in_have_right;
    have_left_nxt  = in_have_left  | is_left;
    left_st_nxt    = is_left  ? st_r : in_left_st;
    left_lo_nxt    = is_left  ? lo_r : in_left_lo;
    left_up_nxt    = is_left  ? up_r : in_left_up;
    have_right_nxt = in_have_right | is_right;
    right_st_nxt   = is_right ? st_r : in_right_st;
    right_lo_nxt   = is_right ? lo_r : in_right_lo;
    right_up_nxt   = is_right ? up_r : in_right_up;
  end

  // Token valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Token payload.
  always_ff @(posedge clk) begin
    s_r          <= in_s;
    have_left_r  <= have_left_nxt;
    left_st_r    <= left_st_nxt;
    left_lo_r    <= left_lo_nxt;
    left_up_r    <= left_up_nxt;
    have_right_r <= have_right_nxt;
    right_st_r   <= right_st_nxt;
    right_lo_r   <= right_lo_nxt;
    right_up_r   <= right_up_nxt;
  end

  assign out_vld        = vld_r;
  assign out_s          = s_r;
  assign out_have_left  = have_left_r;
  assign out_left_st    = left_st_r;
  assign out_left_lo    = left_lo_r;
  assign out_left_up    = left_up_r;
  assign out_have_right = have_right_r;
  assign out_right_st   = right_st_r;
  assign out_right_lo   = right_lo_r;
  assign out_right_up   = right_up_r;

endmodule

@@ hw/rtl/plbl_interp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbl_interp
// Serial restoring divider for the Q0.16 weight, followed by one shared
// multiplier that blends the lower and then the upper bound.
// ----------------------------------------------------------------------------
module plbl_interp #(
  parameter int STATION_BITS = 24,
  parameter int BOUND_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [STATION_BITS-1:0] s,
  input  logic [STATION_BITS-1:0] left_st,
  input  logic [BOUND_BITS-1:0]   left_lo,
  input  logic [BOUND_BITS-1:0]   left_up,
  input  logic [STATION_BITS-1:0] right_st,
  input  logic [BOUND_BITS-1:0]   right_lo,
  input  logic [BOUND_BITS-1:0]   right_up,
  output logic                    done,
  output logic [BOUND_BITS-1:0]   lo_out,
  output logic [BOUND_BITS-1:0]   up_out
);

  localparam int WB = plbl_pkg::WEIGHT_BITS;
  localparam int PW = BOUND_BITS + WB + 2;
  localparam int KW = $clog2(WB);

  plbl_pkg::ip_state_t state_r, state_nxt;
  logic [KW-1:0]           cnt_r, cnt_nxt;
  logic [STATION_BITS-1:0] span_r, span_nxt;
  logic [STATION_BITS-1:0] rem_r, rem_nxt;
  logic [WB-1:0]           q_r, q_nxt;
  logic [BOUND_BITS-1:0]   a_lo_r, a_lo_nxt, b_lo_r, b_lo_nxt;
  logic [BOUND_BITS-1:0]   a_up_r, a_up_nxt, b_up_r, b_up_nxt;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic [BOUND_BITS-1:0]   lo_r, lo_nxt, up_r, up_nxt;

  logic [STATION_BITS:0]   rem2;
  logic                    qbit;
  logic signed [BOUND_BITS:0] diff;
  logic [BOUND_BITS-1:0]   a_sel, b_sel;
  logic signed [PW-1:0]    rnd;
  logic [BOUND_BITS-1:0]   step;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plbl_pkg::IP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    span_r <= span_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    a_lo_r <= a_lo_nxt;
    b_lo_r <= b_lo_nxt;
    a_up_r <= a_up_nxt;
    b_up_r <= b_up_nxt;
    prod_r <= prod_nxt;
    lo_r   <= lo_nxt;
    up_r   <= up_nxt;
  end

  // One quotient bit per cycle; the remainder stays below the span.
  assign rem2 = {rem_r, 1'b0};
  assign qbit = (rem2 >= {1'b0, span_r});

  // Shared multiplier: (b - a) * w, and rounding of the held product.
  assign a_sel = (state_r == plbl_pkg::IP_MUL_LO) ? a_lo_r : a_up_r;
  assign b_sel = (state_r == plbl_pkg::IP_MUL_LO) ? b_lo_r : b_up_r;
  assign diff  = $signed({b_sel[BOUND_BITS-1], b_sel}) -
                 $signed({a_sel[BOUND_BITS-1], a_sel});
  assign rnd   = prod_r + PW'(plbl_pkg::WEIGHT_HALF);
  assign step  = rnd[BOUND_BITS+WB-1:WB];

  // Next state and datapath control.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    span_nxt  = span_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    a_lo_nxt  = a_lo_r;
    b_lo_nxt  = b_lo_r;
    a_up_nxt  = a_up_r;
    b_up_nxt  = b_up_r;
    prod_nxt  = prod_r;
    lo_nxt    = lo_r;
    up_nxt    = up_r;
    done      = 1'b0;
    unique case (state_r)
      plbl_pkg::IP_IDLE: begin
        if (start) begin
          span_nxt  = right_st - left_st;
          rem_nxt   = s - left_st;
          q_nxt     = '0;
          cnt_nxt   = '0;
          a_lo_nxt  = left_lo;
          b_lo_nxt  = right_lo;
          a_up_nxt  = left_up;
          b_up_nxt  = right_up;
          state_nxt = plbl_pkg::IP_DIV;
        end
      end
      plbl_pkg::IP_DIV: begin
        rem_nxt = qbit ? STATION_BITS'(rem2 - {1'b0, span_r}) : rem2[STATION_BITS-1:0];
        q_nxt   = {q_r[WB-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == KW'(WB - 1)) begin
          state_nxt = plbl_pkg::IP_MUL_LO;
        end
      end
      plbl_pkg::IP_MUL_LO: begin
        prod_nxt  = diff * $signed({1'b0, q_r});
        state_nxt = plbl_pkg::IP_MUL_UP;
      end
      plbl_pkg::IP_MUL_UP: begin
        lo_nxt    = a_lo_r + step;
        prod_nxt  = diff * $signed({1'b0, q_r});
        state_nxt = plbl_pkg::IP_ADD_UP;
      end
      plbl_pkg::IP_ADD_UP: begin
        up_nxt    = a_up_r + step;
        state_nxt = plbl_pkg::IP_DONE;
      end
      plbl_pkg::IP_DONE: begin
        done      = 1'b1;
        state_nxt = plbl_pkg::IP_IDLE;
      end
      default: begin
        state_nxt = plbl_pkg::IP_IDLE;
      end
    endcase
  end

  assign lo_out = lo_r;
  assign up_out = up_r;

  // Checks.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == plbl_pkg::IP_IDLE) else $error("start while busy");
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == plbl_pkg::IP_DIV |-> rem_r < span_r) else $error("remainder overflow");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");

endmodule

@@ dv/plbl_lookup_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbl_lookup_checker
// Watches the command and result channels of the bound lookup block, keeps
// its own copy of the point table, and compares every result beat with the
// bounds and status that the accepted command beats call for.
// ----------------------------------------------------------------------------
module plbl_lookup_checker #(
  parameter int TABLE_DEPTH  = 256,
  parameter int STATION_BITS = 24,
  parameter int BOUND_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [STATION_BITS-1:0] in_station,
  input  logic signed [BOUND_BITS-1:0] in_lower,
  input  logic signed [BOUND_BITS-1:0] in_upper,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic signed [BOUND_BITS-1:0] out_lower,
  input  logic signed [BOUND_BITS-1:0] out_upper,
  input  logic [2:0]  out_status,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic signed [BOUND_BITS-1:0] lower;
    logic signed [BOUND_BITS-1:0] upper;
    logic [2:0]                   status;
  } bound_result_t;

  logic [STATION_BITS-1:0]      tbl_station [TABLE_DEPTH];
  logic signed [BOUND_BITS-1:0] tbl_lower   [TABLE_DEPTH];
  logic signed [BOUND_BITS-1:0] tbl_upper   [TABLE_DEPTH];
  int                           tbl_count;
  bound_result_t                expected_bounds [$];

  assign pending_results = expected_bounds.size();

  // Blend two bounds with a Q0.16 weight, rounding half up.
  function automatic logic signed [BOUND_BITS-1:0] blend_bound(
    input logic signed [BOUND_BITS-1:0] a,
    input logic signed [BOUND_BITS-1:0] b,
    input longint w
  );
    longint sum;
    sum = longint'(a) * (65536 - w) + longint'(b) * w + plbl_pkg::WEIGHT_HALF;
    return BOUND_BITS'(sum >>> plbl_pkg::WEIGHT_BITS);
  endfunction

  // Apply one command beat to the table copy and return its result.
  function automatic bound_result_t lookup_bounds(
    input logic [1:0] cmd,
    input logic [STATION_BITS-1:0] s,
    input logic signed [BOUND_BITS-1:0] lo,
    input logic signed [BOUND_BITS-1:0] hi
  );
    bound_result_t r;
    int left, right, mid;
    longint w;
    r = '0;
    r.status = plbl_pkg::ST_OK;
    case (cmd)
      plbl_pkg::CMD_CLEAR: begin
        tbl_count = 0;
      end
      plbl_pkg::CMD_APPEND: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = plbl_pkg::ST_FULL;
        end else if (tbl_count > 0 && s <= tbl_station[tbl_count-1]) begin
          r.status = plbl_pkg::ST_ORDER;
        end else begin
          tbl_station[tbl_count] = s;
          tbl_lower[tbl_count] = lo;
          tbl_upper[tbl_count] = hi;
          tbl_count++;
        end
      end
      plbl_pkg::CMD_QUERY: begin
        if (tbl_count == 0) begin
          r.status = plbl_pkg::ST_EMPTY;
        end else if (s <= tbl_station[0]) begin
          r.lower = tbl_lower[0];
          r.upper = tbl_upper[0];
          r.status = (s < tbl_station[0]) ? plbl_pkg::ST_LOW : plbl_pkg::ST_OK;
        end else if (s >= tbl_station[tbl_count-1]) begin
          r.lower = tbl_lower[tbl_count-1];
          r.upper = tbl_upper[tbl_count-1];
          r.status = (s > tbl_station[tbl_count-1]) ? plbl_pkg::ST_HIGH : plbl_pkg::ST_OK;
        end else begin
          left = 0;
          right = tbl_count - 1;
          while (right - left > 1) begin
            mid = left + (right - left) / 2;
            if (tbl_station[mid] < s) left = mid;
            else right = mid;
          end
          w = (longint'(s - tbl_station[left]) << plbl_pkg::WEIGHT_BITS)
              / longint'(tbl_station[right] - tbl_station[left]);
          r.lower = blend_bound(tbl_lower[left], tbl_lower[right], w);
          r.upper = blend_bound(tbl_upper[left], tbl_upper[right], w);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Predict on accepted command beats, compare on accepted result beats.
  always @(posedge clk) begin
    bound_result_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      tbl_count = 0;
      fail_count <= 0;
      expected_bounds.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_bounds.push_back(lookup_bounds(in_cmd, in_station, in_lower, in_upper));
      end
      if (out_valid && out_ready) begin
        if (expected_bounds.size() == 0) begin
          $error("result beat with nothing expected");
          errs++;
        end else begin
          exp_r = expected_bounds.pop_front();
          if (out_lower !== exp_r.lower) begin
            $error("lower_out: expected %0d, actual %0d", exp_r.lower, out_lower);
            errs++;
          end
          if (out_upper !== exp_r.upper) begin
            $error("upper_out: expected %0d, actual %0d", exp_r.upper, out_upper);
            errs++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_status);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ dv/piecewise_linear_bound_lookup_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_bound_lookup_top_test
// Drives command beats into the bound lookup block: directed corner cases,
// then random tables built and queried, under several idling patterns. A
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module piecewise_linear_bound_lookup_top_test;

  localparam int TABLE_DEPTH   = 256;
  localparam int STATION_BITS  = 24;
  localparam int BOUND_BITS    = 16;
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_BEATS  = 1050;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic [STATION_BITS-1:0] last_station;

  plbl_in_if  #(.STATION_BITS(STATION_BITS), .BOUND_BITS(BOUND_BITS)) cmd_ch ();
  plbl_out_if #(.BOUND_BITS(BOUND_BITS)) res_ch ();

  piecewise_linear_bound_lookup_top #(
    .TABLE_DEPTH(TABLE_DEPTH), .STATION_BITS(STATION_BITS), .BOUND_BITS(BOUND_BITS)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .in_beat(cmd_ch.sink), .out_beat(res_ch.source)
  );

  plbl_lookup_checker #(
    .TABLE_DEPTH(TABLE_DEPTH), .STATION_BITS(STATION_BITS), .BOUND_BITS(BOUND_BITS)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(cmd_ch.valid), .in_ready(cmd_ch.ready), .in_cmd(cmd_ch.cmd),
    .in_station(cmd_ch.station), .in_lower(cmd_ch.lower_in), .in_upper(cmd_ch.upper_in),
    .out_valid(res_ch.valid), .out_ready(res_ch.ready), .out_lower(res_ch.lower_out),
    .out_upper(res_ch.upper_out), .out_status(res_ch.status),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random, changed at the falling edge.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("piecewise_linear_bound_lookup_top verification failed");
        $finish;
      end
    end
  end

  // Offer one command beat and hold it until accepted. Valid drops only
  // while the sender idles, so beats can follow back to back.
  task automatic send_beat(input logic [1:0] cmd, input logic [STATION_BITS-1:0] s,
                           input logic signed [BOUND_BITS-1:0] lo,
                           input logic signed [BOUND_BITS-1:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= cmd;
    cmd_ch.station  <= s;
    cmd_ch.lower_in <= lo;
    cmd_ch.upper_in <= hi;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  // Random bound covering all bits, with extremes now and then.
  function automatic logic signed [BOUND_BITS-1:0] rand_bound();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return BOUND_BITS'($urandom);
    endcase
  endfunction

  // Clear, build a table of the given number of points, and query it.
  task automatic table_session(input int points, input int queries);
    logic [STATION_BITS-1:0] s;
    int step_max;
    send_beat(plbl_pkg::CMD_CLEAR, STATION_BITS'($urandom), rand_bound(), rand_bound());
    step_max = $urandom_range(1) ? 16 : (1 << 24) / (points + 1);
    last_station = STATION_BITS'($urandom_range(3) == 0 ? 0 : $urandom_range(4000));
    for (int i = 0; i < points; i++) begin
      if ($urandom_range(15) == 0 && i > 0)
        send_beat(plbl_pkg::CMD_APPEND, last_station - STATION_BITS'($urandom_range(1)),
                  rand_bound(), rand_bound());
      s = (i == 0) ? last_station : last_station + STATION_BITS'($urandom_range(1, step_max));
      if (s < last_station) s = STATION_BITS'(24'hffffff);
      send_beat(plbl_pkg::CMD_APPEND, s, rand_bound(), rand_bound());
      last_station = s;
    end
    for (int q = 0; q < queries; q++) begin
      case ($urandom_range(9))
        0: s = STATION_BITS'($urandom);
        1: s = last_station;
        2: s = 24'hffffff;
        3: s = 0;
        default: s = STATION_BITS'($urandom_range(last_station));
      endcase
      send_beat($urandom_range(30) == 0 ? plbl_pkg::CMD_UNUSED : plbl_pkg::CMD_QUERY, s,
                rand_bound(), rand_bound());
    end
  endtask

  initial begin
    int sent;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = plbl_pkg::CMD_CLEAR;
    cmd_ch.station = '0;
    cmd_ch.lower_in = '0;
    cmd_ch.upper_in = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty query, unused command, extremes, exact ends, order and a single point.
    send_beat(plbl_pkg::CMD_QUERY, 24'd100, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_UNUSED, 24'hffffff, 16'sh7fff, 16'sh8000);
    send_beat(plbl_pkg::CMD_APPEND, 24'd0, 16'sh8000, 16'sh7fff);
    send_beat(plbl_pkg::CMD_APPEND, 24'd0, 16'sd1, 16'sd1);
    send_beat(plbl_pkg::CMD_APPEND, 24'd3, 16'sh7fff, 16'sh8000);
    send_beat(plbl_pkg::CMD_APPEND, 24'hffffff, 16'sd5, -16'sd5);
    send_beat(plbl_pkg::CMD_QUERY, 24'd0, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_QUERY, 24'd1, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_QUERY, 24'd2, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_QUERY, 24'd3, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_QUERY, 24'h800000, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_QUERY, 24'hffffff, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_CLEAR, 24'd0, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_APPEND, 24'd50, 16'sd7, 16'sd9);
    send_beat(plbl_pkg::CMD_QUERY, 24'd49, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_QUERY, 24'd51, 16'sd0, 16'sd0);
    send_beat(plbl_pkg::CMD_QUERY, 24'd50, 16'sd0, 16'sd0);

    // Fill the table to the top, then overflow it once.
    send_beat(plbl_pkg::CMD_CLEAR, 24'd0, 16'sd0, 16'sd0);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_beat(plbl_pkg::CMD_APPEND, STATION_BITS'(i * 65000 + $urandom_range(100)),
                rand_bound(), rand_bound());
    send_beat(plbl_pkg::CMD_APPEND, 24'hffffff, 16'sd1, 16'sd1);
    for (int q = 0; q < 20; q++)
      send_beat(plbl_pkg::CMD_QUERY, STATION_BITS'($urandom), 16'sd0, 16'sd0);

    // Random sessions over the idling phases.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      case ((sent * 5) / RANDOM_BEATS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        3: begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      begin
        int pts, qs;
        pts = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        qs = $urandom_range(4, 20);
        table_session(pts, qs);
        sent += pts + qs + 1;
      end
    end

    cmd_ch.valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 50) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("piecewise_linear_bound_lookup_top verification clean");
    else
      $display("piecewise_linear_bound_lookup_top verification failed");
    $finish;
  end

endmodule
